FILE: rtl/core/sha256_pkg.sv
package sha256_pkg;

    localparam int unsigned NumRounds = 64;

    typedef logic [31:0] word32_t;

    function automatic word32_t round_const(input logic [5:0] idx);
        word32_t k;
        k = 32'h0;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word32_t init_hash(input logic [2:0] idx);
        word32_t h;
        h = 32'h0;
        unique case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
        endcase
        return h;
    endfunction

    localparam logic [7:0] PadMarker = 8'h80;

endpackage

FILE: rtl/core/sha256_stream_hasher.sv
// Input: a byte that does not fill a block is taken without a stall. A byte that fills one
// stalls the input through load, 64 rounds at one a cycle, and fold.
// Message end: padding bytes go into the buffer memory one per cycle up to byte 55 (byte 63 for
// the first of two blocks); 8 length bytes follow; each padded block, one or two, is compressed.
// Throughput: one byte per cycle while the input is not stalled; then four 64-bit digest parts, one per handshake.
// Reset (rst_n low, async): chaining words to the initial hash, counts to zero.
module sha256_stream_hasher
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_part,
    output logic [1:0]  part_number,
    output logic        last_part
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD,
        S_LEN,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } state_t;

    // Block buffer memory: 16 words of 32 bits, byte-write enabled, registered read.
    word32_t buf_mem [16];

    state_t        state_reg, state_next;
    word32_t       hash_reg [8];
    word32_t       wv_reg [8];   // a..h
    logic [5:0]    fill_reg;
    logic [63:0]   total_reg;
    logic [6:0]    rnd_reg;
    logic          final_reg;    // this compression ends the message
    logic          second_reg;   // a further padded block follows
    logic [1:0]    part_reg;
    logic          out_valid_reg;
    logic          pad_first_reg; // 0x80 marker still to be written

    // Schedule window: the last 16 W values in a shift of registers;
    // win_reg[i] holds w[t-16+i] during round t, so taps sit at fixed places.
    word32_t       win_reg [16];

    logic          accept;
    logic [3:0]    wr_word;
    logic [1:0]    wr_lane;
    logic [7:0]    wr_byte;
    logic          wr_en;
    word32_t       rd_word_reg;
    logic [3:0]    rd_addr;
    logic [63:0]   bit_len;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign last_part = (part_reg == 2'd3);
    assign part_number = part_reg;
    assign digest_part = {hash_reg[{part_reg, 1'b0}], hash_reg[{part_reg, 1'b1}]};
    assign bit_len   = {total_reg[60:0], 3'b000};

    // Buffer write port select.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_byte = data_byte;
        wr_word = fill_reg[5:2];
        wr_lane = fill_reg[1:0];
        if (state_reg == S_IDLE && accept && byte_present)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_PAD)
        begin
            wr_en   = 1'b1;
            wr_byte = pad_first_reg ? PadMarker : 8'h00;
        end
        else if (state_reg == S_LEN)
        begin
            wr_en   = 1'b1;
            // bytes 56..63 take the bit length, most significant first
            wr_byte = bit_len[{~fill_reg[2:0], 3'b000} +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            unique case (wr_lane)
                2'd0: buf_mem[wr_word][31:24] <= wr_byte;
                2'd1: buf_mem[wr_word][23:16] <= wr_byte;
                2'd2: buf_mem[wr_word][15:8]  <= wr_byte;
                default: buf_mem[wr_word][7:0] <= wr_byte;
            endcase
        end
    end

    // The buffer read runs one word ahead of the round counter:
    // S_LOAD primes word 0, round t reads word t+1.
    assign rd_addr = (state_reg == S_ROUND) ? rnd_reg[3:0] + 4'd1 : 4'd0;
    always_ff @(posedge clk)
    begin
        rd_word_reg <= buf_mem[rd_addr];
    end

    // Schedule: W for round t (t from rnd counter during S_ROUND).
    word32_t w_cur, p15, p2, sg0, sg1, s1, ch, t1, s0, mj;
    always_comb
    begin
        p15 = win_reg[1];
        p2  = win_reg[14];
        sg0 = {p15[6:0], p15[31:7]} ^ {p15[17:0], p15[31:18]} ^ (p15 >> 3);
        sg1 = {p2[16:0], p2[31:17]} ^ {p2[18:0], p2[31:19]} ^ (p2 >> 10);
        if (rnd_reg < 7'd16)
            w_cur = rd_word_reg;
        else
            w_cur = win_reg[0] + sg0 + win_reg[9] + sg1;
        s1 = {wv_reg[4][5:0], wv_reg[4][31:6]} ^ {wv_reg[4][10:0], wv_reg[4][31:11]}
           ^ {wv_reg[4][24:0], wv_reg[4][31:25]};
        ch = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        t1 = wv_reg[7] + s1 + ch + round_const(rnd_reg[5:0]) + w_cur;
        s0 = {wv_reg[0][1:0], wv_reg[0][31:2]} ^ {wv_reg[0][12:0], wv_reg[0][31:13]}
           ^ {wv_reg[0][21:0], wv_reg[0][31:22]};
        mj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present && fill_reg == 6'd63)
                        state_next = S_LOAD;
                    else if (message_end)
                        state_next = S_PAD;
                end
            end
            S_PAD:  if (fill_reg == 6'd55 && !second_reg) state_next = S_LEN;
                    else if (fill_reg == 6'd63) state_next = S_LOAD;
            S_LEN:  if (fill_reg == 6'd63) state_next = S_LOAD;
            S_LOAD: state_next = S_ROUND;
            S_ROUND: if (rnd_reg == 7'd63) state_next = S_FOLD;
            S_FOLD:
            begin
                if (second_reg)      state_next = S_PAD;
                else if (final_reg)  state_next = S_EMIT;
                else                 state_next = S_IDLE;
            end
            S_EMIT: if (!out_stall && part_reg == 2'd3) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            total_reg     <= '0;
            rnd_reg       <= '0;
            final_reg     <= 1'b0;
            second_reg    <= 1'b0;
            part_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= init_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        logic [5:0] f;
                        f = fill_reg;
                        if (byte_present)
                        begin
                            total_reg <= total_reg + 64'd1;
                            f = fill_reg + 6'd1;
                        end
                        final_reg <= message_end;
                        if (byte_present && fill_reg == 6'd63)
                        begin
                            // full block first; an end word pads a fresh block after it
                            fill_reg   <= 6'd0;
                            second_reg <= message_end;
                        end
                        else if (message_end)
                        begin
                            // 0x80 marker goes in the S_PAD first cycle's slot
                            fill_reg   <= f;
                            second_reg <= (f > 6'd55);
                        end
                        else
                            fill_reg <= f;
                    end
                end
                S_PAD, S_LEN:
                begin
                    // wraps to 0 after byte 63
                    fill_reg <= fill_reg + 6'd1;
                end
                S_LOAD: rnd_reg <= 7'd0;
                S_ROUND: rnd_reg <= rnd_reg + 7'd1;
                S_FOLD:
                begin
                    rnd_reg <= 7'd0;
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + wv_reg[i];
                    if (second_reg)
                    begin
                        second_reg <= 1'b0;
                        fill_reg   <= 6'd0;
                    end
                    else if (final_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        part_reg      <= 2'd0;
                    end
                end
                S_EMIT:
                begin
                    if (!out_stall)
                    begin
                        part_reg <= part_reg + 2'd1;
                        if (part_reg == 2'd3)
                        begin
                            out_valid_reg <= 1'b0;
                            final_reg     <= 1'b0;
                            total_reg     <= '0;
                            fill_reg      <= '0;
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= init_hash(3'(i));
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Round datapath and schedule window taps.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            for (int i = 0; i < 8; i++)
                wv_reg[i] <= hash_reg[i];
        end
        else if (state_reg == S_ROUND)
        begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + s0 + mj;
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= w_cur;
        end
    end

    // Marker pending from the end word until the first S_PAD cycle; it waits
    // out the compression when the end word also filled a block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pad_first_reg <= 1'b0;
        else if (accept && message_end)
            pad_first_reg <= 1'b1;
        else if (state_reg == S_PAD)
            pad_first_reg <= 1'b0;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_EMIT)
        else $error("digest shown outside emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> rnd_reg < 7'd64)
        else $error("round counter overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(part_reg))
        else $error("part advanced while stalled");

endmodule
